### rtl/camera_follow_scroll_unit_assert.svh
// assertion macros for the camera follow scroll unit
`ifndef CAMERA_FOLLOW_SCROLL_UNIT_ASSERT_SVH
`define CAMERA_FOLLOW_SCROLL_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define CFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every clock edge, reset included
`define CFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cfs_pkg.sv
package cfs_pkg;

  // screen size in pixels
  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 160;

  // field widths
  localparam int POS_W   = 16;
  localparam int ROOM_W  = 13;
  localparam int SPD_W   = 8;
  localparam int SCR_W   = 11;
  localparam int IDX_W   = 3;
  localparam int CFG_D_W = 16;

  // internal arithmetic width, holds every sum and distance
  localparam int AW = 19;

  localparam logic signed [AW-1:0] POS_MAX = AW'(32767);
  localparam logic signed [AW-1:0] POS_MIN = -AW'(32768);

  // register indexes
  localparam logic [IDX_W-1:0] REG_ROOM_LEFT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROOM_TOP     = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROOM_WIDTH   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROOM_HEIGHT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCROLL_SPEED = 3'd4;

  // register reset values
  localparam logic [ROOM_W-1:0] ROOM_WIDTH_RST  = 13'd240;
  localparam logic [ROOM_W-1:0] ROOM_HEIGHT_RST = 13'd160;
  localparam logic [SPD_W-1:0]  SPEED_RST       = 8'd4;

  // mode codes
  localparam logic FUNC_FOLLOW = 1'b0;
  localparam logic FUNC_SNAP   = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] room_left;
    logic signed [POS_W-1:0] room_top;
    logic [ROOM_W-1:0]       room_width;
    logic [ROOM_W-1:0]       room_height;
    logic [SPD_W-1:0]        scroll_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic                    limited;
    logic                    tile_hit;
  } axis_res_t;

endpackage

### rtl/cfs_regs.sv
module cfs_regs
  import cfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [CFG_D_W-1:0] wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;

  // register write decode, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.room_left    <= '0;
      cfg_r.room_top     <= '0;
      cfg_r.room_width   <= ROOM_WIDTH_RST;
      cfg_r.room_height  <= ROOM_HEIGHT_RST;
      cfg_r.scroll_speed <= SPEED_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROOM_LEFT:    cfg_r.room_left    <= $signed(wr_data);
        REG_ROOM_TOP:     cfg_r.room_top     <= $signed(wr_data);
        REG_ROOM_WIDTH:   cfg_r.room_width   <= wr_data[ROOM_W-1:0];
        REG_ROOM_HEIGHT:  cfg_r.room_height  <= wr_data[ROOM_W-1:0];
        REG_SCROLL_SPEED: cfg_r.scroll_speed <= wr_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/cfs_axis.sv
module cfs_axis
  import cfs_pkg::*;
(
  input  logic                    snap,
  input  logic signed [POS_W-1:0] pos,
  input  logic signed [POS_W-1:0] tgt,
  input  logic signed [POS_W-1:0] org,
  input  logic [ROOM_W-1:0]       room,
  input  logic [SCR_W-1:0]        screen,
  input  logic [SPD_W-1:0]        speed,
  output axis_res_t               res
);

  logic signed [AW-1:0] pos_w, tgt_w, org_w, room_w, scr_w, half_w, spd_w, low3_w;
  logic signed [AW-1:0] e_raw, e_w, gap, stp, np;
  logic                 lim, hit;

  // sign and zero extension into the working width
  assign pos_w  = {{(AW-POS_W){pos[POS_W-1]}}, pos};
  assign tgt_w  = {{(AW-POS_W){tgt[POS_W-1]}}, tgt};
  assign org_w  = {{(AW-POS_W){org[POS_W-1]}}, org};
  assign room_w = $signed({{(AW-ROOM_W){1'b0}}, room});
  assign scr_w  = $signed({{(AW-SCR_W){1'b0}}, screen});
  assign half_w = $signed({{(AW-SCR_W+1){1'b0}}, screen[SCR_W-1:1]});
  assign spd_w  = $signed({{(AW-SPD_W){1'b0}}, speed});
  assign low3_w = $signed({{(AW-3){1'b0}}, pos[2:0]});

  // upper scroll bound, saturated to the position range
  assign e_raw = org_w + room_w - scr_w;
  always_comb begin
    if (e_raw > POS_MAX)      e_w = POS_MAX;
    else if (e_raw < POS_MIN) e_w = POS_MIN;
    else                      e_w = e_raw;
  end

  assign gap = pos_w - (tgt_w - half_w);

  // follow step or snap placement
  always_comb begin
    stp = gap;
    np  = pos_w;
    lim = 1'b0;
    hit = 1'b0;
    if (snap) begin
      hit = 1'b1;
      if (tgt_w <= org_w + half_w)    np = org_w;
      else if (tgt_w >= e_w + half_w) np = e_w;
      else                            np = tgt_w - half_w;
    end else if (gap > 0) begin
      if (org_w < pos_w) begin
        if (spd_w <= gap) begin
          stp = spd_w;
          lim = 1'b1;
        end
        np = pos_w - stp;
        if (low3_w - stp < 1) hit = 1'b1;
        if (org_w >= np) np = org_w;
      end
    end else if (gap < 0) begin
      if (pos_w < e_w) begin
        if (-spd_w >= gap) begin
          stp = -spd_w;
          lim = 1'b1;
        end
        np = pos_w - stp;
        if (low3_w - stp > 7) hit = 1'b1;
        if (np >= e_w) np = e_w;
      end
    end
  end

  assign res.pos      = np[POS_W-1:0];
  assign res.limited  = lim;
  assign res.tile_hit = hit;

endmodule

### rtl/camera_follow_scroll_unit.sv
// out_tvalid rises once an input transfer has passed the input register and then the result register
// throughput: one item per cycle while out_tready is high; the scroll position register feeds the next item directly
// a held result does not block input: one more item waits in the input register
// reset (rst_n low, synchronous): both stages empty, scroll position 0, registers to defaults
// configuration writes are taken every cycle (cfg_ready stays high)
module camera_follow_scroll_unit
  import cfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,  // target_x[15:0], target_y[31:16]
  input  logic [0:0]         in_tuser,  // func[0]
  // result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [39:0]        out_tdata, // view_x[15:0], view_y[31:16],
                                        // speed_limited[32], tiles_refresh[33], zero[39:34]
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data
);

  cfg_t cfg;

  logic                    v1_r;
  logic                    func_r;
  logic signed [POS_W-1:0] tx_r, ty_r;
  logic signed [POS_W-1:0] pos_x_r, pos_y_r;
  logic                    out_valid_r;
  logic [39:0]             out_data_r;
  axis_res_t               ax_x, ax_y;
  logic                    adv;
  logic [39:0]             out_nxt;

  assign cfg_ready = 1'b1;

  cfs_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // result register free or draining this cycle
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !v1_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r <= in_tuser[0];
      tx_r   <= $signed(in_tdata[15:0]);
      ty_r   <= $signed(in_tdata[31:16]);
    end
  end

  cfs_axis u_axis_x (
    .snap   (func_r == FUNC_SNAP),
    .pos    (pos_x_r),
    .tgt    (tx_r),
    .org    (cfg.room_left),
    .room   (cfg.room_width),
    .screen (SCR_W'(SCREEN_WIDTH)),
    .speed  (cfg.scroll_speed),
    .res    (ax_x)
  );

  cfs_axis u_axis_y (
    .snap   (func_r == FUNC_SNAP),
    .pos    (pos_y_r),
    .tgt    (ty_r),
    .org    (cfg.room_top),
    .room   (cfg.room_height),
    .screen (SCR_W'(SCREEN_HEIGHT)),
    .speed  (cfg.scroll_speed),
    .res    (ax_y)
  );

  assign out_nxt = {6'd0, ax_x.tile_hit | ax_y.tile_hit, ax_x.limited | ax_y.limited,
                    ax_y.pos, ax_x.pos};

  // result register and scroll position update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
    end else if (adv) begin
      out_valid_r <= v1_r;
      if (v1_r) begin
        pos_x_r <= ax_x.pos;
        pos_y_r <= ax_y.pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/cfs_checker.sv
`include "camera_follow_scroll_unit_assert.svh"

module cfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result stays
  `CFS_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // input backpressure only while a result is waiting
  `CFS_ASSERT(a_in_stall, clk, rst_n, !in_tready |-> out_tvalid, "input stalled with empty output")

  // reset empties the result register
  `CFS_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // padding bits of a result are zero
  `CFS_ASSERT(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[39:34] == 6'd0, "nonzero padding in result")

endmodule

bind camera_follow_scroll_unit cfs_checker u_cfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
